// File: src/pcr_pkg.sv
// shared constants, types and helpers for the particle contact resolver
package pcr_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int IN_BITS     = 344;
    localparam int OUT_BITS    = 256;
    localparam int DIV_STAGES  = 8;
    localparam int DIV_STEP    = 4;
    localparam int NUM_DIV     = 4;
    localparam int NUM_PROD    = 8;
    localparam int NUM_STAGES  = 17;
    localparam int NUM_CTX     = 16;
    localparam logic [30:0] TIMESTEP_RESET = 31'd1092;

    localparam logic signed [63:0] S32_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] S32_MIN = 64'shFFFF_FFFF_8000_0000;

    // contact fields carried alongside the arithmetic
    typedef struct packed {
        logic signed [31:0] vel0_x;
        logic signed [31:0] vel0_y;
        logic signed [31:0] vel1_x;
        logic signed [31:0] vel1_y;
        logic signed [17:0] normal_x;
        logic signed [17:0] normal_y;
        logic [30:0]        inv_mass0;
        logic [30:0]        inv_mass1;
        logic signed [31:0] penetration;
        logic [16:0]        restitution;
    } ctx_t;

    // clamp to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > S32_MAX)
            r = S32_MAX[31:0];
        else if (x < S32_MIN)
            r = S32_MIN[31:0];
        else
            r = x[31:0];
        return r;
    endfunction

endpackage

// File: src/particle_contact_resolver_core.sv
// Throughput: one contact per cycle; the 32-bit share quotients come from an
// eight-stage restoring divider, four quotient bits per stage.
// The whole pipeline stalls while a result waits on the output side.
// Reset (rst_n low, asynchronous) clears all valid bits and sets timestep to 1092.
// top level of the particle contact resolver
module particle_contact_resolver_core (
    input  logic                         clk,
    input  logic                         rst_n,
    // vel0_x, vel0_y, vel1_x, vel1_y, rel_acc_x, rel_acc_y, inv_mass0,
    // inv_mass1, normal_x, normal_y, penetration, restitution, zero pad
    input  logic [pcr_pkg::IN_BITS-1:0]  s_tdata,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // new_vel0_x, new_vel0_y, new_vel1_x, new_vel1_y,
    // move0_x, move0_y, move1_x, move1_y
    output logic [pcr_pkg::OUT_BITS-1:0] m_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic [30:0]                  cfg_data,
    input  logic                         cfg_valid,
    output logic                         cfg_ready
);
    import pcr_pkg::*;

    logic        en;
    logic [30:0] timestep_reg;
    logic [NUM_STAGES-1:0] vld_reg;
    ctx_t        ctx_reg [NUM_CTX];
    ctx_t        ctx_in;
    logic signed [31:0] acc_x_in, acc_y_in;

    logic signed [50:0] s1_pdx_reg, s1_pdy_reg;
    logic signed [49:0] s1_pax_reg, s1_pay_reg;
    logic signed [31:0] s2_sep_reg, s2_accn_reg;
    logic signed [31:0] s3_sep_reg;
    logic signed [50:0] s3_pne_reg;
    logic signed [63:0] s3_pat_reg;
    logic signed [31:0] s4_sep_reg, s4_nsep_reg, s4_accsep_reg;
    logic signed [31:0] s5_sep_reg, s5_nsep_reg;
    logic               s5_neg_reg;
    logic signed [49:0] s5_pea_reg;
    logic [31:0]        s6_delta_reg;
    logic [62:0]        s7_prod_reg [NUM_DIV];
    logic [31:0]        s7_den_reg;
    logic [31:0]        dv_rem_reg  [DIV_STAGES][NUM_DIV];
    logic [31:0]        dv_word_reg [DIV_STAGES][NUM_DIV];
    logic [31:0]        dv_den_reg  [DIV_STAGES];
    logic signed [50:0] s16_prod_reg [NUM_PROD];
    logic [OUT_BITS-1:0] out_reg;

    // pipeline advances unless a result is held on the output side
    assign en        = !vld_reg[NUM_STAGES-1] || m_tready;
    assign s_tready  = en;
    assign m_tvalid  = vld_reg[NUM_STAGES-1];
    assign m_tdata   = out_reg;
    assign cfg_ready = 1'b1;

    // timestep register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            timestep_reg <= TIMESTEP_RESET;
        else if (cfg_valid && cfg_ready)
            timestep_reg <= cfg_data;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NUM_STAGES-2:0], s_tvalid};
    end

    // unpack input transfer
    always_comb
    begin
        ctx_in.vel0_x      = s_tdata[31:0];
        ctx_in.vel0_y      = s_tdata[63:32];
        ctx_in.vel1_x      = s_tdata[95:64];
        ctx_in.vel1_y      = s_tdata[127:96];
        acc_x_in           = s_tdata[159:128];
        acc_y_in           = s_tdata[191:160];
        ctx_in.inv_mass0   = s_tdata[222:192];
        ctx_in.inv_mass1   = s_tdata[253:223];
        ctx_in.normal_x    = s_tdata[271:254];
        ctx_in.normal_y    = s_tdata[289:272];
        ctx_in.penetration = s_tdata[321:290];
        ctx_in.restitution = s_tdata[338:322];
    end

    // context shift line
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctx_reg[0] <= ctx_in;
            for (int i = 1; i < NUM_CTX; i++)
                ctx_reg[i] <= ctx_reg[i-1];
        end
    end

    // stage 1: normal products of relative velocity and acceleration
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_pdx_reg <= (33'(ctx_in.vel0_x) - 33'(ctx_in.vel1_x)) * ctx_in.normal_x;
            s1_pdy_reg <= (33'(ctx_in.vel0_y) - 33'(ctx_in.vel1_y)) * ctx_in.normal_y;
            s1_pax_reg <= acc_x_in * ctx_in.normal_x;
            s1_pay_reg <= acc_y_in * ctx_in.normal_y;
        end
    end

    // stage 2: separating velocity and normal acceleration
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_sep_reg  <= sat32(64'((52'(s1_pdx_reg) + 52'(s1_pdy_reg)) >>> FRAC_BITS));
            s2_accn_reg <= sat32(64'((51'(s1_pax_reg) + 51'(s1_pay_reg)) >>> FRAC_BITS));
        end
    end

    // stage 3: restitution and timestep products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_sep_reg <= s2_sep_reg;
            s3_pne_reg <= (-(33'(s2_sep_reg))) * $signed({1'b0, ctx_reg[1].restitution});
            s3_pat_reg <= s2_accn_reg * $signed({1'b0, timestep_reg});
        end
    end

    // stage 4: scale back both products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_sep_reg    <= s3_sep_reg;
            s4_nsep_reg   <= sat32(64'(s3_pne_reg >>> FRAC_BITS));
            s4_accsep_reg <= sat32(s3_pat_reg >>> FRAC_BITS);
        end
    end

    // stage 5: restitution times acceleration build-up
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_sep_reg  <= s4_sep_reg;
            s5_nsep_reg <= s4_nsep_reg;
            s5_neg_reg  <= s4_accsep_reg[31];
            s5_pea_reg  <= $signed({1'b0, ctx_reg[3].restitution}) * s4_accsep_reg;
        end
    end

    // stage 6: remove build-up, clamp and form the velocity change
    always_ff @(posedge clk)
    begin
        logic signed [31:0] trim;
        logic signed [31:0] ns;
        logic signed [32:0] dlt;
        if (en)
        begin
            trim = sat32(64'(s5_pea_reg >>> FRAC_BITS));
            ns   = s5_nsep_reg;
            if (s5_neg_reg)
            begin
                ns = sat32(64'(ns) + 64'(trim));
                if (ns < 0)
                    ns = '0;
            end
            dlt = 33'(ns) - 33'(s5_sep_reg);
            if (s5_sep_reg > 0)
                s6_delta_reg <= '0;
            else
                s6_delta_reg <= dlt[31:0];
        end
    end

    // stage 7: dividends for the inverse-mass shares
    always_ff @(posedge clk)
    begin
        logic [30:0] pen_u;
        logic [31:0] total;
        if (en)
        begin
            pen_u = (ctx_reg[5].penetration > 0) ? ctx_reg[5].penetration[30:0] : '0;
            total = 32'(ctx_reg[5].inv_mass0) + 32'(ctx_reg[5].inv_mass1);
            s7_prod_reg[0] <= 63'(s6_delta_reg) * 63'(ctx_reg[5].inv_mass0);
            s7_prod_reg[1] <= 63'(s6_delta_reg) * 63'(ctx_reg[5].inv_mass1);
            s7_prod_reg[2] <= 63'(pen_u) * 63'(ctx_reg[5].inv_mass0);
            s7_prod_reg[3] <= 63'(pen_u) * 63'(ctx_reg[5].inv_mass1);
            // zero total mass: dividends are zero, a unit divisor keeps quotients zero
            s7_den_reg     <= (total == '0) ? 32'd1 : total;
        end
    end

    // stages 8 to 15: restoring divider, four quotient bits per stage
    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_div
        always_ff @(posedge clk)
        begin
            logic [31:0] rem;
            logic [31:0] word;
            logic [31:0] den;
            logic [32:0] trial;
            if (en)
            begin
                den = (k == 0) ? s7_den_reg : dv_den_reg[(k == 0) ? 0 : k-1];
                for (int j = 0; j < NUM_DIV; j++)
                begin
                    if (k == 0)
                    begin
                        rem  = {1'b0, s7_prod_reg[j][62:32]};
                        word = s7_prod_reg[j][31:0];
                    end
                    else
                    begin
                        rem  = dv_rem_reg[(k == 0) ? 0 : k-1][j];
                        word = dv_word_reg[(k == 0) ? 0 : k-1][j];
                    end
                    for (int b = 0; b < DIV_STEP; b++)
                    begin
                        trial = {rem, word[31]};
                        if (trial >= {1'b0, den})
                        begin
                            trial = trial - {1'b0, den};
                            word  = {word[30:0], 1'b1};
                        end
                        else
                            word  = {word[30:0], 1'b0};
                        rem = trial[31:0];
                    end
                    dv_rem_reg[k][j]  <= rem;
                    dv_word_reg[k][j] <= word;
                end
                dv_den_reg[k] <= den;
            end
        end
    end

    // stage 16: shares along the normal, second particle pushed the other way
    always_ff @(posedge clk)
    begin
        logic signed [17:0] nx;
        logic signed [17:0] ny;
        if (en)
        begin
            nx = ctx_reg[14].normal_x;
            ny = ctx_reg[14].normal_y;
            for (int j = 0; j < NUM_DIV; j++)
            begin
                if (j[0] == 1'b0)
                begin
                    s16_prod_reg[2*j]   <= nx * $signed({1'b0, dv_word_reg[DIV_STAGES-1][j]});
                    s16_prod_reg[2*j+1] <= ny * $signed({1'b0, dv_word_reg[DIV_STAGES-1][j]});
                end
                else
                begin
                    s16_prod_reg[2*j]   <= -(nx * $signed({1'b0, dv_word_reg[DIV_STAGES-1][j]}));
                    s16_prod_reg[2*j+1] <= -(ny * $signed({1'b0, dv_word_reg[DIV_STAGES-1][j]}));
                end
            end
        end
    end

    // stage 17: apply velocity changes and saturate into the output register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg[31:0]    <= sat32(64'(ctx_reg[15].vel0_x)
                                      + 64'(s16_prod_reg[0] >>> FRAC_BITS));
            out_reg[63:32]   <= sat32(64'(ctx_reg[15].vel0_y)
                                      + 64'(s16_prod_reg[1] >>> FRAC_BITS));
            out_reg[95:64]   <= sat32(64'(ctx_reg[15].vel1_x)
                                      + 64'(s16_prod_reg[2] >>> FRAC_BITS));
            out_reg[127:96]  <= sat32(64'(ctx_reg[15].vel1_y)
                                      + 64'(s16_prod_reg[3] >>> FRAC_BITS));
            out_reg[159:128] <= sat32(64'(s16_prod_reg[4] >>> FRAC_BITS));
            out_reg[191:160] <= sat32(64'(s16_prod_reg[5] >>> FRAC_BITS));
            out_reg[223:192] <= sat32(64'(s16_prod_reg[6] >>> FRAC_BITS));
            out_reg[255:224] <= sat32(64'(s16_prod_reg[7] >>> FRAC_BITS));
        end
    end

`ifndef SYNTHESIS
    // an accepted contact enters the first stage
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> vld_reg[0])
        else $error("accepted contact missing from first stage");

    // a held result stalls the input side
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while output stalled");

    // divider remainder stays below the divisor
    a_rem: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[14] |-> dv_rem_reg[DIV_STAGES-1][0] < dv_den_reg[DIV_STAGES-1])
        else $error("divider remainder out of range");
`endif

endmodule
